// ----- hdl/rrkvc_pkg.sv -----
// Package for the random replacement key-value cache.
// Holds the word types, the access mode codes and the shared constants.
// No dependencies; every other file in hdl uses it by scoped names.
package rrkvc_pkg;

   // Default number of entry slots in the store.
   localparam int MAX_ENTRIES_DEFAULT = 16;

   // Width of the capacity register and its reset value.
   localparam int CAP_W = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Victim generator: 16-bit Galois LFSR, x^16+x^14+x^13+x^11+1.
   localparam int LFSR_W = 16;
   localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
   localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

   // Width of keys and values, and what a get miss returns.
   localparam int DATA_W = 32;
   localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;

   typedef enum logic {
      MODE_GET = 1'b0,
      MODE_PUT = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type                  mode;
      logic signed [DATA_W-1:0]  lookup_key;
      logic signed [DATA_W-1:0]  write_value;
   } req_type;

   typedef struct packed {
      logic                      found;
      logic signed [DATA_W-1:0]  read_value;
      logic                      evicted;
      logic signed [DATA_W-1:0]  evicted_key;
   } rsp_type;

   // Write command from the access control to the entry store.
   typedef struct packed {
      logic write_en;
      logic fill_inc;
   } store_ctl_type;

   // Lookup status from the entry store.
   typedef struct packed {
      logic                      hit;
      logic signed [DATA_W-1:0]  hit_value;
      logic signed [DATA_W-1:0]  victim_key;
   } store_status_type;

endpackage

// ----- hdl/random_replacement_kv_cache_core.sv -----
// Top level of the random replacement key-value cache.
// Instantiates rrkvc_entry_store and rrkvc_victim_gen; uses rrkvc_pkg.
//
//   Channel  Ports                                   Direction  Word
//   request  req_valid, req_stall, req_word          in         rrkvc_pkg::req_type
//   response rsp_valid, rsp_stall, rsp_word          out        rrkvc_pkg::rsp_type
//   config   csr_write_enable, csr_write_data        in         capacity_ff
//
// One access per cycle while the output does not stall: a word accepted at an
// edge is held in the input register and compared against all slots; at the
// edge the output register takes it, it is applied and its response registered.
// Synchronous active-high reset empties both registers, clears the fill count,
// seeds the LFSR and sets the capacity to 16; slot contents are left as they are.
// A stalled response word holds the output register; with the input register
// also full, req_stall follows rsp_stall in the same cycle.
module random_replacement_kv_cache_core #(
   parameter int MAX_ENTRIES = rrkvc_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  rrkvc_pkg::req_type            req_word,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output rrkvc_pkg::rsp_type            rsp_word,
   input  logic                          csr_write_enable,
   input  logic [rrkvc_pkg::CAP_W-1:0]   csr_write_data
);

   localparam int IDX_W     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
   localparam int CAP_EXT_W = (CNT_W > rrkvc_pkg::CAP_W) ? CNT_W : rrkvc_pkg::CAP_W;

   // Input register.
   logic                         req_valid_ff;
   logic                         req_valid_in;
   rrkvc_pkg::req_type           req_ff;

   // Output register.
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   rrkvc_pkg::rsp_type           rsp_ff;
   rrkvc_pkg::rsp_type           rsp_in;

   // Capacity register.
   logic [rrkvc_pkg::CAP_W-1:0]  capacity_ff;
   logic [rrkvc_pkg::CAP_W-1:0]  capacity_in;

   logic [CAP_EXT_W-1:0]         capacity_ext;
   logic [CNT_W-1:0]             capacity_eff;
   logic                         advance;
   logic                         fire;
   logic                         room;
   logic                         evict;
   logic [IDX_W-1:0]             victim_index;
   logic [IDX_W-1:0]             hit_index;
   logic [IDX_W-1:0]             write_index;
   logic [CNT_W-1:0]             fill_count;
   rrkvc_pkg::store_ctl_type     store_ctl;
   rrkvc_pkg::store_status_type  store_status;

   // The output register can take a new word when it is empty or its word
   // leaves at this edge. The held access is processed at that same edge.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = req_valid_ff && advance;
   assign req_stall = req_valid_ff && !advance;

   // Capacity of zero acts as one; anything above the slot count acts as the
   // slot count.
   always_comb begin
      capacity_ext = CAP_EXT_W'(capacity_ff);
      if (capacity_ext == '0) begin
         capacity_eff = CNT_W'(1);
      end else if (capacity_ext > CAP_EXT_W'(MAX_ENTRIES)) begin
         capacity_eff = CNT_W'(MAX_ENTRIES);
      end else begin
         capacity_eff = capacity_ext[CNT_W-1:0];
      end
   end

   assign room = fill_count < capacity_eff;

   // Decide the response and the store update for the held access. A put
   // always writes: at the hit slot, at the next free slot, or at the victim.
   // A free slot index is below the capacity and so fits the index width.
   always_comb begin
      store_ctl          = '0;
      evict              = 1'b0;
      write_index        = hit_index;
      rsp_in.found       = store_status.hit;
      rsp_in.read_value  = '0;
      rsp_in.evicted     = 1'b0;
      rsp_in.evicted_key = '0;
      case (req_ff.mode)
         rrkvc_pkg::MODE_GET: begin
            rsp_in.read_value = store_status.hit ? store_status.hit_value
                                                 : rrkvc_pkg::MISS_VALUE;
         end
         rrkvc_pkg::MODE_PUT: begin
            store_ctl.write_en = fire;
            if (!store_status.hit) begin
               if (room) begin
                  store_ctl.fill_inc = 1'b1;
                  write_index        = fill_count[IDX_W-1:0];
               end else begin
                  evict              = fire;
                  write_index        = victim_index;
                  rsp_in.evicted     = 1'b1;
                  rsp_in.evicted_key = store_status.victim_key;
               end
            end
         end
         default: begin
            store_ctl = '0;
         end
      endcase
   end

   rrkvc_entry_store #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_store (
      .clock        (clock),
      .reset        (reset),
      .lookup_key   (req_ff.lookup_key),
      .victim_index (victim_index),
      .ctl          (store_ctl),
      .write_index  (write_index),
      .write_value  (req_ff.write_value),
      .status       (store_status),
      .hit_index    (hit_index),
      .fill_count   (fill_count)
   );

   rrkvc_victim_gen #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_victim (
      .clock        (clock),
      .reset        (reset),
      .capacity     (capacity_eff),
      .advance      (evict),
      .victim_index (victim_index)
   );

   // The input register loads whenever it is not stalled.
   assign req_valid_in = req_stall ? req_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         req_ff <= req_word;
      end
   end

   assign rsp_valid_in = advance ? req_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign capacity_in = csr_write_enable ? csr_write_data : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         capacity_ff  <= rrkvc_pkg::CAP_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         capacity_ff  <= capacity_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_evict_is_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.found && rsp_ff.evicted))
      else $error("response reports both a hit and an eviction");

   a_evict_only_full: assert property (@(posedge clock) disable iff (reset)
      evict |-> !room && !store_status.hit && req_ff.mode == rrkvc_pkg::MODE_PUT)
      else $error("eviction with a free slot or on a hit");

   a_fire_fills_output: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("processed access left no response");
`endif

endmodule

// ----- hdl/rrkvc_entry_store.sv -----
// Entry store of the random replacement key-value cache: key and value
// registers, fill count, parallel key compare and the read selects.
// Depends on rrkvc_pkg.
module rrkvc_entry_store #(
   parameter int MAX_ENTRIES = rrkvc_pkg::MAX_ENTRIES_DEFAULT,
   parameter int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
   parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic signed [rrkvc_pkg::DATA_W-1:0]    lookup_key,
   input  logic [IDX_W-1:0]                       victim_index,
   input  rrkvc_pkg::store_ctl_type               ctl,
   input  logic [IDX_W-1:0]                       write_index,
   input  logic signed [rrkvc_pkg::DATA_W-1:0]    write_value,
   output rrkvc_pkg::store_status_type            status,
   output logic [IDX_W-1:0]                       hit_index,
   output logic [CNT_W-1:0]                       fill_count
);

   logic signed [rrkvc_pkg::DATA_W-1:0] keys_ff   [MAX_ENTRIES];
   logic signed [rrkvc_pkg::DATA_W-1:0] values_ff [MAX_ENTRIES];
   logic [CNT_W-1:0]                    fill_ff;
   logic [CNT_W-1:0]                    fill_in;
   logic [MAX_ENTRIES-1:0]              match_vec;
   logic [IDX_W-1:0]                    hit_index_or;
   logic signed [rrkvc_pkg::DATA_W-1:0] hit_value_or;

   // Keys are unique among held slots, so at most one slot matches and the
   // index and value can be built as a plain OR over the matching slot.
   always_comb begin
      hit_index_or = '0;
      hit_value_or = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         match_vec[i] = (CNT_W'(i) < fill_ff) && (keys_ff[i] == lookup_key);
         if (match_vec[i]) begin
            hit_index_or = hit_index_or | IDX_W'(i);
            hit_value_or = hit_value_or | values_ff[i];
         end
      end
   end

   assign status.hit        = |match_vec;
   assign status.hit_value  = hit_value_or;
   assign status.victim_key = keys_ff[victim_index];
   assign hit_index         = hit_index_or;
   assign fill_count        = fill_ff;

   always_ff @(posedge clock) begin
      if (ctl.write_en) begin
         keys_ff[write_index]   <= lookup_key;
         values_ff[write_index] <= write_value;
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (ctl.write_en && ctl.fill_inc) begin
         fill_in = fill_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_unique_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("more than one held slot matches the key");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(MAX_ENTRIES))
      else $error("fill count beyond the number of slots");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      ctl.write_en && ctl.fill_inc |=> fill_ff == $past(fill_ff) + CNT_W'(1))
      else $error("fill count did not advance on a fill");
`endif

endmodule

// ----- hdl/rrkvc_victim_gen.sv -----
// Victim generator of the random replacement key-value cache: the LFSR and
// the scaling of its value onto the effective capacity.
// Depends on rrkvc_pkg.
module rrkvc_victim_gen #(
   parameter int MAX_ENTRIES = rrkvc_pkg::MAX_ENTRIES_DEFAULT,
   parameter int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
   parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [CNT_W-1:0]   capacity,
   input  logic               advance,
   output logic [IDX_W-1:0]   victim_index
);

   localparam int PROD_W = rrkvc_pkg::LFSR_W + CNT_W;

   logic [rrkvc_pkg::LFSR_W-1:0] lfsr_ff;
   logic [rrkvc_pkg::LFSR_W-1:0] lfsr_in;
   logic [PROD_W-1:0]            product;

   // The scaled value is below the capacity, which never exceeds the slot
   // count, so the low bits of the upper part are the whole index.
   assign product      = PROD_W'(lfsr_ff) * PROD_W'(capacity);
   assign victim_index = product[rrkvc_pkg::LFSR_W +: IDX_W];

   always_comb begin
      lfsr_in = lfsr_ff;
      if (advance) begin
         lfsr_in = {1'b0, lfsr_ff[rrkvc_pkg::LFSR_W-1:1]};
         if (lfsr_ff[0]) begin
            lfsr_in = lfsr_in ^ rrkvc_pkg::LFSR_TAPS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= rrkvc_pkg::LFSR_SEED;
      end else begin
         lfsr_ff <= lfsr_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_lfsr_nonzero: assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != '0)
      else $error("LFSR reached the all-zero lockup state");

   a_lfsr_moves: assert property (@(posedge clock) disable iff (reset)
      advance |=> lfsr_ff != $past(lfsr_ff))
      else $error("LFSR did not move on an eviction");

   a_lfsr_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> lfsr_ff == $past(lfsr_ff))
      else $error("LFSR moved without an eviction");
`endif

endmodule
